// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types, widths and status codes of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int unsigned POOL_BYTES_DEF   = 262144;
	localparam int unsigned HEADER_BYTES_DEF = 12;
	localparam int unsigned MAX_BLOCKS_DEF   = 64;
	localparam int unsigned AW               = 18;
	localparam logic [7:0]  SPLIT_MIN_RESET  = 8'd16;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_IGNORED   = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_OOM       = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NOT_BLOCK = 3'd5,
		ST_DOUBLE    = 3'd6
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	// Table entry: header offset, payload length and used mark.
	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] length;
		logic          used;
	} entry_t;

endpackage

// ===== rtl/ffpa_table.sv =====
// ----------------------------------------------------------------------------
// ffpa_table
// Block table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffpa_table import ffpa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/first_fit_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit pool allocator with splitting and coalescing of free blocks.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the in_ channel (opcode, request_bytes,
// payload_offset) is taken when in_valid and in_ready are both high. Exactly
// one result transaction follows on the out_ channel with status, grant
// offset and the running free and used payload totals.
// One request is handled at a time; in_ready is low from acceptance until
// the result has been taken. The block table is a memory with one write port
// and one registered read port, walked by a small sequencer that sets the
// address and then uses the registered read for each entry.
// An allocate takes the scan plus, on a split, the shift that opens a slot;
// a free takes the scan, the shift that closes gaps on merging, and at most
// two merges. After reset the table holds one free block and the block is
// ready at once; split_min returns to 16. If the receiver stalls, the result
// is held in the output register and no new request is taken.
// split_min may be written through cfg_ when idle.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator import ffpa_pkg::*; #(
	parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          opcode,
	input  logic [31:0]   request_bytes,
	input  logic [AW-1:0] payload_offset,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [AW-1:0] grant_offset,
	output logic [AW-1:0] free_total,
	output logic [AW-1:0] used_total
);

	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [AW-1:0] HDR      = AW'(HEADER_BYTES);
	localparam logic [AW-1:0] PAY_MAX  = AW'(POOL_BYTES - HEADER_BYTES);
	localparam logic [AW:0]   POOL_LIM = (AW+1)'(POOL_BYTES);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCHK, S_OPEN_RD, S_OPEN_WR, S_SPLIT,
		S_MRD, S_MCHK, S_CLOSE_RD, S_CLOSE_WR, S_DONE
	} state_t;

	state_t          state_q;
	logic [7:0]      split_min_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   free_q, used_q;
	logic            op_q;
	logic [AW-1:0]   size_q, off_q;
	logic [AW-1:0]   rem_q;
	logic [CW-1:0]   idx_q, k_q;
	entry_t          hit_q, prev_q;
	logic            prev_ok_q;
	logic            e0_init_q;
	logic [2:0]      st_q;
	logic [AW-1:0]   grant_q;
	logic            out_valid_q;

	logic            we;
	logic [IW-1:0]   waddr, raddr;
	entry_t          wdata, rd_raw, rd;

	ffpa_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_raw)
	);

	// Entry 0 reads as its reset contents until it is first written.
	logic rd_is0_q;
	always_comb begin
		rd = rd_raw;
		if (rd_is0_q && !e0_init_q) begin
			rd = '{start: '0, length: PAY_MAX, used: 1'b0};
		end
	end

	logic [32:0]   req_round;
	logic [AW+1:0] need;
	logic [AW:0]   hit_end;
	always_comb begin
		req_round = ({1'b0, request_bytes} + 33'd3) & ~33'd3;
		need      = {2'b0, size_q} + {2'b0, HDR} + (AW+2)'(split_min_q);
		hit_end   = {1'b0, rd.start} + {1'b0, HDR};
	end

	assign cfg_ready    = (state_q == S_IDLE) && !out_valid_q;
	assign in_ready     = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid    = out_valid_q;
	assign status       = st_q;
	assign grant_offset = grant_q;
	assign free_total   = free_q;
	assign used_total   = used_q;

	// Memory port control.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = hit_q;
		raddr = idx_q[IW-1:0];
		case (state_q)
			S_OPEN_RD:  raddr = IW'(k_q - CW'(1));
			S_OPEN_WR: begin
				we    = 1'b1;
				waddr = k_q[IW-1:0];
				wdata = rd;
			end
			S_SPLIT: begin
				we    = 1'b1;
				waddr = IW'(idx_q + CW'(1));
				wdata = '{start: hit_q.start + HDR + size_q, length: rem_q, used: 1'b0};
			end
			S_MRD:      raddr = IW'(idx_q + CW'(1));
			S_CLOSE_RD: raddr = IW'(k_q + CW'(1));
			S_CLOSE_WR: begin
				we    = 1'b1;
				waddr = k_q[IW-1:0];
				wdata = rd;
			end
			// The updated block itself is written back once all shifting is over.
			S_DONE: begin
				we    = (st_q == ST_OK);
				wdata = hit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			split_min_q <= SPLIT_MIN_RESET;
			count_q     <= CW'(1);
			free_q      <= PAY_MAX;
			used_q      <= '0;
			e0_init_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rd_is0_q    <= 1'b0;
			op_q        <= 1'b0;
			idx_q       <= '0;
			k_q         <= '0;
			prev_ok_q   <= 1'b0;
			st_q        <= '0;
			grant_q     <= '0;
			size_q      <= '0;
			off_q       <= '0;
			rem_q       <= '0;
			hit_q       <= '0;
			prev_q      <= '0;
		end else begin
			rd_is0_q <= (raddr == '0);
			if (we && waddr == '0) begin
				e0_init_q <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						split_min_q <= cfg_data;
					end
					if (in_valid && in_ready) begin
						op_q      <= opcode;
						size_q    <= req_round[AW-1:0];
						off_q     <= payload_offset;
						idx_q     <= '0;
						grant_q   <= '0;
						prev_ok_q <= 1'b0;
						if (opcode == OP_ALLOC) begin
							if (request_bytes == '0) begin
								st_q  <= ST_IGNORED;
								state_q <= S_DONE;
							end else if (request_bytes > 32'(PAY_MAX)) begin
								st_q  <= ST_TOO_LARGE;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SRD;
							end
						end else if (payload_offset == '0) begin
							st_q    <= ST_IGNORED;
							state_q <= S_DONE;
						end else if (payload_offset < HDR ||
								{1'b0, payload_offset} >= POOL_LIM) begin
							st_q    <= ST_OUTSIDE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (idx_q >= count_q) begin
						st_q    <= (op_q == OP_ALLOC) ? ST_OOM : ST_NOT_BLOCK;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (op_q == OP_ALLOC) begin
						if (!rd.used && rd.length >= size_q) begin
							st_q    <= ST_OK;
							grant_q <= hit_end[AW-1:0];
							if ({2'b0, rd.length} > need && count_q < CNT_MAX) begin
								hit_q   <= '{start: rd.start, length: size_q, used: 1'b1};
								rem_q   <= rd.length - size_q - HDR;
								free_q  <= free_q - size_q - HDR;
								used_q  <= used_q + size_q;
								k_q     <= count_q;
								count_q <= count_q + CW'(1);
								state_q <= S_OPEN_RD;
							end else begin
								hit_q   <= '{start: rd.start, length: rd.length, used: 1'b1};
								free_q  <= free_q - rd.length;
								used_q  <= used_q + rd.length;
								state_q <= S_DONE;
							end
						end else begin
							prev_q    <= rd;
							prev_ok_q <= 1'b1;
							idx_q     <= idx_q + CW'(1);
							state_q   <= S_SRD;
						end
					end else if (hit_end == {1'b0, off_q}) begin
						if (!rd.used) begin
							st_q    <= ST_DOUBLE;
							state_q <= S_DONE;
						end else begin
							st_q    <= ST_OK;
							used_q  <= used_q - rd.length;
							// Merge backwards first if the previous block is free.
							if (prev_ok_q && !prev_q.used) begin
								hit_q   <= '{start: prev_q.start,
									length: prev_q.length + HDR + rd.length,
									used: 1'b0};
								free_q  <= free_q + rd.length + HDR;
								k_q     <= idx_q;
								idx_q   <= idx_q - CW'(1);
								state_q <= S_CLOSE_RD;
							end else begin
								hit_q   <= '{start: rd.start, length: rd.length, used: 1'b0};
								free_q  <= free_q + rd.length;
								state_q <= S_MRD;
							end
						end
					end else begin
						prev_q    <= rd;
						prev_ok_q <= 1'b1;
						idx_q     <= idx_q + CW'(1);
						state_q   <= S_SRD;
					end
				end
				// Shift entries idx+1..count-2 up by one, from the top.
				S_OPEN_RD: begin
					if (k_q > idx_q + CW'(1)) begin
						state_q <= S_OPEN_WR;
					end else begin
						state_q <= S_SPLIT;
					end
				end
				S_OPEN_WR: begin
					k_q     <= k_q - CW'(1);
					state_q <= S_OPEN_RD;
				end
				S_SPLIT: state_q <= S_DONE;
				// Free path: read the next entry for a forward merge.
				S_MRD: begin
					if (idx_q + CW'(1) >= count_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MCHK;
					end
				end
				S_MCHK: begin
					// The port now returns the entry after the freed block.
					if (!rd.used) begin
						hit_q.length <= hit_q.length + HDR + rd.length;
						free_q  <= free_q + HDR;
						k_q     <= idx_q + CW'(1);
						state_q <= S_CLOSE_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Drop entry k by moving later entries down one place.
				S_CLOSE_RD: begin
					if (k_q + CW'(1) < count_q) begin
						state_q <= S_CLOSE_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_MRD;
					end
				end
				S_CLOSE_WR: begin
					k_q     <= k_q + CW'(1);
					state_q <= S_CLOSE_RD;
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the allocator's handshakes and results.
// ----------------------------------------------------------------------------
module ffpa_checker import ffpa_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          cfg_ready,
	input logic [2:0]    status,
	input logic [AW-1:0] grant_offset
);

	// A held result keeps its status until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// No new request is taken while a result waits.
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request accepted with result pending");

	// An accepted request blocks the input on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after acceptance");

	// Grants only come with success.
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> grant_offset == '0)
		else $error("grant without success");

	// Configuration is only taken when idle.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> in_ready)
		else $error("configuration taken while busy");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.cfg_ready   (cfg_ready),
	.status      (status),
	.grant_offset(grant_offset)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit pool allocator. A queue of pending
// steps drives allocate and free requests, split_min writes and idle waits.
// A built-in table model predicts each result, and the monitor compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module testbench import ffpa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POOL   = POOL_BYTES_DEF;
	localparam int unsigned HDR    = HEADER_BYTES_DEF;
	localparam int unsigned SLOTS  = MAX_BLOCKS_DEF;
	localparam int          SETTLE = 4 * SLOTS + 40;

	typedef enum {K_REQ, K_CFG, K_DRAIN, K_MODE} step_kind_t;
	typedef enum {F_GIVEN, F_LIVE, F_NEAR, F_STALE} free_pick_t;

	typedef struct {
		step_kind_t    kind;
		opcode_t       op;
		logic [31:0]   bytes;
		logic [AW-1:0] offset;
		free_pick_t    pick;
		int            a;
		int            b;
	} step_t;

	typedef struct {
		status_t       st;
		logic [AW-1:0] grant;
		logic [AW-1:0] free_b;
		logic [AW-1:0] used_b;
	} outcome_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [7:0]    cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic          opcode = 1'b0;
	logic [31:0]   request_bytes = '0;
	logic [AW-1:0] payload_offset = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [2:0]    status;
	logic [AW-1:0] grant_offset;
	logic [AW-1:0] free_total;
	logic [AW-1:0] used_total;

	step_t         steps_q[$];
	outcome_t      expected_q[$];
	logic [AW-1:0] live_q[$];
	logic [AW-1:0] stale_q[$];

	// Model of the block table.
	logic [AW-1:0] tbl_start[SLOTS];
	logic [AW-1:0] tbl_len[SLOTS];
	logic          tbl_used[SLOTS];
	int            tbl_count;
	logic [AW-1:0] model_free_sum;
	logic [AW-1:0] model_used_sum;
	logic [7:0]    split_threshold;

	int  errors = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  drain_cycles = 0;
	bit  stimulus_ready = 0;
	bit  next_in_valid;
	bit  next_cfg_valid;
	step_t    head;
	outcome_t got;

	first_fit_pool_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.request_bytes(request_bytes), .payload_offset(payload_offset),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.grant_offset(grant_offset), .free_total(free_total), .used_total(used_total)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic void shift_down(input int idx);
		for (int k = idx; k + 1 < tbl_count; k++) begin
			tbl_start[k] = tbl_start[k + 1];
			tbl_len[k]   = tbl_len[k + 1];
			tbl_used[k]  = tbl_used[k + 1];
		end
		tbl_count--;
	endfunction

	function automatic outcome_t predict_request(input opcode_t op, input logic [31:0] req,
			input logic [AW-1:0] off);
		outcome_t r;
		longint   size;
		longint   len;
		int       i;
		bit       done;
		r.st = ST_OOM;
		r.grant = '0;
		done = 0;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				r.st = ST_IGNORED;
			end else if (longint'(req) > longint'(POOL - HDR)) begin
				r.st = ST_TOO_LARGE;
			end else begin
				size = (longint'(req) + 3) & ~longint'(3);
				for (i = 0; i < tbl_count && !done; i++) begin
					len = tbl_len[i];
					if (!tbl_used[i] && len >= size) begin
						if (len > size + HDR + split_threshold && tbl_count < SLOTS) begin
							for (int k = tbl_count; k > i + 1; k--) begin
								tbl_start[k] = tbl_start[k - 1];
								tbl_len[k]   = tbl_len[k - 1];
								tbl_used[k]  = tbl_used[k - 1];
							end
							tbl_start[i + 1] = AW'(tbl_start[i] + HDR + size);
							tbl_len[i + 1]   = AW'(len - size - HDR);
							tbl_used[i + 1]  = 1'b0;
							tbl_count++;
							tbl_len[i] = AW'(size);
							model_free_sum = AW'(model_free_sum - len + tbl_len[i + 1]);
							model_used_sum = AW'(model_used_sum + size);
						end else begin
							model_free_sum = AW'(model_free_sum - len);
							model_used_sum = AW'(model_used_sum + len);
						end
						tbl_used[i] = 1'b1;
						r.grant = AW'(tbl_start[i] + HDR);
						r.st = ST_OK;
						live_q.push_back(r.grant);
						done = 1;
					end
				end
			end
		end else begin
			if (off == 0) begin
				r.st = ST_IGNORED;
			end else if (off < HDR) begin
				r.st = ST_OUTSIDE;
			end else begin
				r.st = ST_NOT_BLOCK;
				for (i = 0; i < tbl_count && !done; i++) begin
					if (tbl_start[i] + HDR == off) begin
						done = 1;
						if (!tbl_used[i]) begin
							r.st = ST_DOUBLE;
						end else begin
							r.st = ST_OK;
							tbl_used[i] = 1'b0;
							model_free_sum = model_free_sum + tbl_len[i];
							model_used_sum = model_used_sum - tbl_len[i];
						end
					end
				end
				if (r.st == ST_OK) begin
					i = 0;
					while (i + 1 < tbl_count) begin
						if (!tbl_used[i] && !tbl_used[i + 1]) begin
							tbl_len[i] = AW'(tbl_len[i] + HDR + tbl_len[i + 1]);
							model_free_sum = AW'(model_free_sum + HDR);
							shift_down(i + 1);
						end else begin
							i++;
						end
					end
					foreach (live_q[j]) if (live_q[j] == off) begin
						live_q.delete(j);
						break;
					end
					stale_q.push_back(off);
					if (stale_q.size() > 16) void'(stale_q.pop_front());
				end
			end
		end
		r.free_b = model_free_sum;
		r.used_b = model_used_sum;
		return r;
	endfunction

	// Free targets are chosen when the request is launched, so they track
	// the blocks that are live at that moment.
	function automatic logic [AW-1:0] choose_offset(input step_t s);
		logic [AW-1:0] o;
		o = s.offset;
		case (s.pick)
			F_LIVE: if (live_q.size() > 0) o = live_q[$urandom_range(live_q.size() - 1)];
			F_NEAR: if (live_q.size() > 0)
				o = AW'(live_q[$urandom_range(live_q.size() - 1)] + 4 * $urandom_range(1, 3));
			F_STALE: if (stale_q.size() > 0) o = stale_q[$urandom_range(stale_q.size() - 1)];
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(predict_request(opcode_t'(opcode), request_bytes,
					payload_offset));
			if (cfg_valid && cfg_ready)
				split_threshold = cfg_data;
			if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
				while (steps_q.size() > 0 && steps_q[0].kind == K_MODE) begin
					send_idle_pct  = steps_q[0].a;
					recv_stall_pct = steps_q[0].b;
					void'(steps_q.pop_front());
				end
				next_in_valid  = 1'b0;
				next_cfg_valid = 1'b0;
				if (steps_q.size() > 0) begin
					head = steps_q[0];
					case (head.kind)
						K_DRAIN: begin
							if (expected_q.size() == 0 && !(in_valid && in_ready))
								drain_cycles++;
							if (drain_cycles >= SETTLE) begin
								drain_cycles = 0;
								void'(steps_q.pop_front());
							end
						end
						K_CFG: begin
							next_cfg_valid = 1'b1;
							cfg_data <= head.a[7:0];
							void'(steps_q.pop_front());
						end
						default: if ($urandom_range(99) >= send_idle_pct) begin
							next_in_valid  = 1'b1;
							opcode         <= head.op;
							request_bytes  <= head.bytes;
							payload_offset <= (head.op == OP_FREE) ? choose_offset(head)
								: AW'($urandom);
							void'(steps_q.pop_front());
						end
					endcase
				end
				in_valid  <= next_in_valid;
				cfg_valid <= next_cfg_valid;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					got = expected_q.pop_front();
					if (status !== got.st)
						report_mismatch($sformatf("status %0d, want %0d", status, got.st));
					if (grant_offset !== got.grant)
						report_mismatch($sformatf("grant %0d, want %0d", grant_offset, got.grant));
					if (free_total !== got.free_b)
						report_mismatch($sformatf("free %0d, want %0d", free_total, got.free_b));
					if (used_total !== got.used_b)
						report_mismatch($sformatf("used %0d, want %0d", used_total, got.used_b));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void add_req(input opcode_t op, input logic [31:0] b,
			input logic [AW-1:0] o, input free_pick_t p);
		step_t s;
		s.kind = K_REQ; s.op = op; s.bytes = b; s.offset = o; s.pick = p; s.a = 0; s.b = 0;
		steps_q.push_back(s);
	endfunction

	function automatic void add_ctl(input step_kind_t k, input int a, input int b);
		step_t s;
		s.kind = k; s.op = OP_ALLOC; s.bytes = '0; s.offset = '0; s.pick = F_GIVEN;
		s.a = a; s.b = b;
		steps_q.push_back(s);
	endfunction

	function automatic logic [31:0] random_size();
		int r;
		r = $urandom_range(99);
		if (r < 2)  return 0;
		if (r < 70) return $urandom_range(1, 512);
		if (r < 85) return $urandom_range(513, 8192);
		if (r < 93) return $urandom_range(8193, POOL - HDR);
		if (r < 96) return $urandom_range(POOL - HDR + 1, 32'h7fffffff);
		return $urandom;
	endfunction

	function automatic void add_random(input int n, input int alloc_pct);
		int r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < alloc_pct) begin
				add_req(OP_ALLOC, random_size(), '0, F_GIVEN);
			end else begin
				r = $urandom_range(99);
				if (r < 70)      add_req(OP_FREE, $urandom, '0, F_LIVE);
				else if (r < 80) add_req(OP_FREE, $urandom, AW'($urandom), F_GIVEN);
				else if (r < 90) add_req(OP_FREE, $urandom, '0, F_NEAR);
				else             add_req(OP_FREE, $urandom, '0, F_STALE);
			end
		end
	endfunction

	initial begin
		tbl_count = 1;
		tbl_start[0] = '0;
		tbl_len[0] = AW'(POOL - HDR);
		tbl_used[0] = 1'b0;
		model_free_sum = AW'(POOL - HDR);
		model_used_sum = '0;
		split_threshold = SPLIT_MIN_RESET;

		// Directed corners: zero, oversized and whole-pool allocations and
		// each kind of bad free.
		add_ctl(K_MODE, 0, 0);
		add_req(OP_ALLOC, 0, '0, F_GIVEN);
		add_req(OP_ALLOC, POOL - HDR + 1, '0, F_GIVEN);
		add_req(OP_ALLOC, 32'hffffffff, '0, F_GIVEN);
		add_req(OP_ALLOC, POOL - HDR, '0, F_GIVEN);
		add_req(OP_ALLOC, 1, '0, F_GIVEN);
		add_req(OP_FREE, 0, HDR, F_GIVEN);
		add_req(OP_FREE, 0, HDR, F_GIVEN);
		add_req(OP_FREE, 0, '0, F_GIVEN);
		add_req(OP_FREE, 0, HDR - 1, F_GIVEN);
		add_req(OP_FREE, 0, '1, F_GIVEN);
		add_req(OP_FREE, 0, 100, F_GIVEN);
		add_req(OP_ALLOC, 1, '0, F_GIVEN);
		add_req(OP_ALLOC, 3, '0, F_GIVEN);
		add_req(OP_ALLOC, 5, '0, F_GIVEN);
		add_req(OP_FREE, 0, HDR + 4 + HDR, F_GIVEN);
		add_req(OP_FREE, 0, HDR, F_GIVEN);
		add_req(OP_ALLOC, POOL - 2 * HDR - 8, '0, F_GIVEN);
		add_req(OP_FREE, 0, HDR + 4 + HDR + 4 + HDR, F_GIVEN);

		// Phases of sender idling, receiver stalls and split_min settings, each entered with the block idle.
		for (int ph = 0; ph < 8; ph++) begin
			add_ctl(K_DRAIN, 0, 0);
			case (ph % 4)
				0: add_ctl(K_MODE, 0, 0);
				1: add_ctl(K_MODE, 55, 0);
				2: add_ctl(K_MODE, 0, 55);
				default: add_ctl(K_MODE, 33, 33);
			endcase
			case (ph)
				0: add_ctl(K_CFG, 0, 0);
				3: add_ctl(K_CFG, 255, 0);
				5: add_ctl(K_CFG, SPLIT_MIN_RESET, 0);
				default: add_ctl(K_CFG, $urandom_range(255), 0);
			endcase
			for (int c = 0; c < 2; c++) begin
				add_random(60, 75);
				add_random(40, 35);
				add_ctl(K_DRAIN, 0, 0);
			end
			add_random(15, 20);
		end
		stimulus_ready = 1;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_ready);
		@(posedge clk);
		while (steps_q.size() > 0 || in_valid || cfg_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

endmodule
